### rtl/c8la_pkg.sv
// Shared types, constants and helper functions for the CHIP-8 line assembler.
`timescale 1ns / 1ps
`default_nettype none
package c8la_pkg;

	localparam int TOKEN_CHARS = 4;
	localparam int LINE_BITS   = 16;
	localparam int TOK_W       = 8 * TOKEN_CHARS;
	localparam int LEN_W       = $clog2(TOKEN_CHARS + 2);
	localparam int NUM_MNEM    = 24;
	localparam int NUM_KW      = 9;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LV    = 8'h76;
	localparam logic [7:0] CH_LI    = 8'h69;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam logic [16:0] ACC_SAT = 17'h10000;

	typedef enum logic [4:0] {
		MN_NONE = 5'd0, MN_SYS = 5'd1, MN_CLS = 5'd2, MN_RET = 5'd3, MN_CALL = 5'd4,
		MN_JMP = 5'd5, MN_SE = 5'd6, MN_SNE = 5'd7, MN_LD = 5'd8, MN_ADD = 5'd9,
		MN_AND = 5'd10, MN_OR = 5'd11, MN_XOR = 5'd12, MN_SUB = 5'd13, MN_SUBN = 5'd14,
		MN_SHR = 5'd15, MN_SHL = 5'd16, MN_RND = 5'd17, MN_DRW = 5'd18, MN_SCD = 5'd19,
		MN_SCR = 5'd20, MN_SCL = 5'd21, MN_EXIT = 5'd22, MN_LOW = 5'd23, MN_HIGH = 5'd24
	} mnem_t;

	typedef enum logic [3:0] {
		CL_ABSENT = 4'd0, CL_REG = 4'd1, CL_NUM = 4'd2, CL_BIG = 4'd3, CL_IWORD = 4'd4,
		CL_KW_I = 4'd5, CL_KW_ST = 4'd6, CL_KW_DT = 4'd7, CL_KW_MEM = 4'd8, CL_KW_F = 4'd9,
		CL_KW_B = 4'd10, CL_KW_HF = 4'd11, CL_KW_R = 4'd12, CL_KW_K = 4'd13
	} cls_t;

	typedef enum logic [1:0] {
		NP_START = 2'd0, NP_SIGN = 2'd1, NP_DIGITS = 2'd2, NP_DONE = 2'd3
	} nphase_t;

	// Token words: first byte in the low bits, unused bytes zero.
	localparam logic [31:0] MNEM_WORD [NUM_MNEM] = '{
		32'h00737973, 32'h00736C63, 32'h00746572, 32'h6C6C6163, 32'h00706D6A,
		32'h00006573, 32'h00656E73, 32'h0000646C, 32'h00646461, 32'h00646E61,
		32'h0000726F, 32'h00726F78, 32'h00627573, 32'h6E627573, 32'h00726873,
		32'h006C6873, 32'h00646E72, 32'h00777264, 32'h00646373, 32'h00726373,
		32'h006C6373, 32'h74697865, 32'h00776F6C, 32'h68676968
	};
	localparam logic [2:0] MNEM_LEN [NUM_MNEM] = '{
		3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3,
		3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd4
	};
	localparam logic [31:0] KW_WORD [NUM_KW] = '{
		32'h00000069, 32'h00007473, 32'h00007464, 32'h005D695B, 32'h00000066,
		32'h00000062, 32'h00006668, 32'h00000072, 32'h0000006B
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd1, 3'd2, 3'd2, 3'd3, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1
	};

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_LA) && (c <= CH_LF));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = (c <= CH_NINE) ? (c - CH_ZERO) : (c - CH_LA + 8'd10);
		return d[3:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage
`default_nettype wire

### rtl/chip8_line_assembler.sv
// Top level of the CHIP-8 / SCHIP line assembler: tokenizer, line state and result register.
`timescale 1ns / 1ps
`default_nettype none
// One source byte is taken per clock on the char channel while it is not stalled; every newline
// yields one registered result beat (opcode, status, line number, oversize flag) on the res channel.
// For each byte, the token and operand registers are updated in a single pass,
// and the line's opcode is assembled from them into the result register on the newline.
// The char channel stalls only while a finished result is held by a stalled res channel.
// Matching ignores case; only the first four bytes of a token are kept for matching.
module chip8_line_assembler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic [7:0]  character,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [15:0]      opcode_word,
	output logic             status,
	output logic [15:0]      line_number,
	output logic             operand_too_large
);

	localparam int TW = c8la_pkg::TOK_W;
	localparam int LW = c8la_pkg::LEN_W;

	// line and token state
	logic [c8la_pkg::LINE_BITS-1:0] line_q;
	logic [2:0]                     pos_q;
	logic [TW-1:0]                  chars_q;
	logic [LW-1:0]                  len_q;
	logic [16:0]                    acc_q;
	c8la_pkg::nphase_t              phase_q;
	logic                           neg_q;
	logic                           hexrun_q;
	logic [3:0]                     rdig_q;
	c8la_pkg::mnem_t                mn_q;
	c8la_pkg::cls_t                 cls_q [3];
	logic [15:0]                    val_q [3];

	// result register
	logic        res_valid_q;
	logic [15:0] op_q;
	logic        status_q;
	logic [15:0] lnum_q;
	logic        big_q;

	logic accept, is_nl, is_sp;
	logic [7:0] lc;

	assign char_stall = res_valid_q & res_stall;
	assign accept     = char_valid & ~char_stall;
	assign is_nl      = (character == c8la_pkg::CH_NL);
	assign is_sp      = (character == c8la_pkg::CH_SP);
	assign lc = ((character >= c8la_pkg::CH_UA) && (character <= c8la_pkg::CH_UZ))
		? (character + 8'd32) : character;

	// classify the current token as mnemonic or operand
	c8la_pkg::mnem_t tok_mn;
	c8la_pkg::cls_t  tok_cls;
	logic [15:0]     tok_val;
	logic [7:0]      c0, c1;
	logic [15:0]     mag;

	always_comb begin
		c0 = chars_q[7:0];
		c1 = chars_q[15:8];
		mag = acc_q[16] ? 16'hFFFF : acc_q[15:0];
		tok_mn = c8la_pkg::MN_NONE;
		for (int i = 0; i < c8la_pkg::NUM_MNEM; i++) begin
			if ((len_q == LW'(c8la_pkg::MNEM_LEN[i])) &&
			    (chars_q == TW'(c8la_pkg::MNEM_WORD[i]))) begin
				tok_mn = c8la_pkg::mnem_t'(5'(i + 1));
			end
		end
		tok_cls = c8la_pkg::CL_ABSENT;
		tok_val = 16'h0000;
		for (int i = c8la_pkg::NUM_KW - 1; i >= 0; i--) begin
			if ((len_q == LW'(c8la_pkg::KW_LEN[i])) &&
			    (chars_q == TW'(c8la_pkg::KW_WORD[i]))) begin
				tok_cls = c8la_pkg::cls_t'(4'(i + 5));
			end
		end
		if (tok_cls == c8la_pkg::CL_ABSENT) begin
			if ((c0 == c8la_pkg::CH_LV) && (len_q >= LW'(2)) && c8la_pkg::is_hex(c1)) begin
				tok_cls = c8la_pkg::CL_REG;
				tok_val = {11'd0, (c1 == c8la_pkg::CH_ZERO), rdig_q};
			end else if (c0 == c8la_pkg::CH_LI) begin
				tok_cls = c8la_pkg::CL_IWORD;
			end else if (neg_q) begin
				tok_cls = c8la_pkg::CL_NUM;
				tok_val = 16'h0000 - mag;
			end else begin
				tok_cls = acc_q[16] ? c8la_pkg::CL_BIG : c8la_pkg::CL_NUM;
				tok_val = mag;
			end
		end
	end

	// line view with the pending token folded in
	c8la_pkg::mnem_t mn_f;
	c8la_pkg::cls_t  cls_f [3];
	logic [15:0]     val_f [3];
	logic [2:0]      pos_f;

	always_comb begin
		mn_f  = mn_q;
		pos_f = pos_q;
		for (int k = 0; k < 3; k++) begin
			cls_f[k] = cls_q[k];
			val_f[k] = val_q[k];
		end
		if (len_q != '0) begin
			if (pos_q == 3'd0) begin
				mn_f = tok_mn;
			end
			for (int k = 0; k < 3; k++) begin
				if (pos_q == 3'(k + 1)) begin
					cls_f[k] = tok_cls;
					val_f[k] = tok_val;
				end
			end
			if (pos_q < 3'd4) begin
				pos_f = pos_q + 3'd1;
			end
		end
	end

	// assemble the opcode for the line
	logic [3:0]  r0, r1;
	logic [15:0] n0, n1, n2, x, xy;
	logic [15:0] op;
	logic        big;

	always_comb begin
		r0 = (cls_f[0] == c8la_pkg::CL_REG) ? val_f[0][3:0] : 4'h0;
		r1 = (cls_f[1] == c8la_pkg::CL_REG) ? val_f[1][3:0] : 4'h0;
		n0 = ((cls_f[0] == c8la_pkg::CL_NUM) || (cls_f[0] == c8la_pkg::CL_BIG)) ? val_f[0] : '0;
		n1 = ((cls_f[1] == c8la_pkg::CL_NUM) || (cls_f[1] == c8la_pkg::CL_BIG)) ? val_f[1] : '0;
		n2 = ((cls_f[2] == c8la_pkg::CL_NUM) || (cls_f[2] == c8la_pkg::CL_BIG)) ? val_f[2] : '0;
		x  = {4'h0, r0, 8'h00};
		xy = {4'h0, r0, r1, 4'h0};
		op  = 16'h0000;
		big = 1'b0;
		unique case (mn_f)
			c8la_pkg::MN_SYS: begin
				op = {4'h0, n0[11:0]}; big = (cls_f[0] == c8la_pkg::CL_BIG);
			end
			c8la_pkg::MN_CLS:  op = 16'h00E0;
			c8la_pkg::MN_RET:  op = 16'h00EE;
			c8la_pkg::MN_CALL: begin
				op = {4'h2, n0[11:0]}; big = (cls_f[0] == c8la_pkg::CL_BIG);
			end
			c8la_pkg::MN_JMP: begin
				if ((cls_f[0] == c8la_pkg::CL_REG) && val_f[0][4]) begin
					op = {4'hB, n1[11:0]}; big = (cls_f[1] == c8la_pkg::CL_BIG);
				end else begin
					op = {4'h1, n0[11:0]}; big = (cls_f[0] == c8la_pkg::CL_BIG);
				end
			end
			c8la_pkg::MN_SE, c8la_pkg::MN_SNE: begin
				if (cls_f[1] == c8la_pkg::CL_REG) begin
					op = xy | ((mn_f == c8la_pkg::MN_SE) ? 16'h5000 : 16'h9000);
				end else begin
					op = x | {8'h00, n1[7:0]} |
						((mn_f == c8la_pkg::MN_SE) ? 16'h3000 : 16'h4000);
					big = (cls_f[1] == c8la_pkg::CL_BIG);
				end
			end
			c8la_pkg::MN_LD: begin
				unique case (cls_f[0])
					c8la_pkg::CL_KW_I: begin
						op = {4'hA, n1[11:0]}; big = (cls_f[1] == c8la_pkg::CL_BIG);
					end
					c8la_pkg::CL_KW_ST:  op = {4'hF, r1, 8'h18};
					c8la_pkg::CL_KW_DT:  op = {4'hF, r1, 8'h15};
					c8la_pkg::CL_KW_MEM: op = {4'hF, r1, 8'h55};
					c8la_pkg::CL_KW_F:   op = {4'hF, r1, 8'h29};
					c8la_pkg::CL_KW_B:   op = {4'hF, r1, 8'h33};
					c8la_pkg::CL_KW_HF:  op = {4'hF, r1, 8'h30};
					c8la_pkg::CL_KW_R:   op = {4'hF, r1, 8'h75};
					default: begin
						unique case (cls_f[1])
							c8la_pkg::CL_KW_DT:  op = 16'hF007 | x;
							c8la_pkg::CL_KW_K:   op = 16'hF00A | x;
							c8la_pkg::CL_KW_MEM: op = 16'hF065 | x;
							c8la_pkg::CL_KW_R:   op = 16'hF085 | x;
							c8la_pkg::CL_REG:    op = 16'h8000 | xy;
							default: begin
								op = 16'h6000 | x | {8'h00, n1[7:0]};
								big = (cls_f[1] == c8la_pkg::CL_BIG);
							end
						endcase
					end
				endcase
			end
			c8la_pkg::MN_ADD: begin
				if ((cls_f[0] == c8la_pkg::CL_KW_I) || (cls_f[0] == c8la_pkg::CL_IWORD)) begin
					op = {4'hF, r1, 8'h1E};
				end else if (cls_f[1] == c8la_pkg::CL_REG) begin
					op = 16'h8004 | xy;
				end else begin
					op = 16'h7000 | x | {8'h00, n1[7:0]};
					big = (cls_f[1] == c8la_pkg::CL_BIG);
				end
			end
			c8la_pkg::MN_AND:  op = 16'h8002 | xy;
			c8la_pkg::MN_OR:   op = 16'h8001 | xy;
			c8la_pkg::MN_XOR:  op = 16'h8003 | xy;
			c8la_pkg::MN_SUB:  op = 16'h8005 | xy;
			c8la_pkg::MN_SUBN: op = 16'h8007 | xy;
			c8la_pkg::MN_SHR:  op = 16'h8006 | x;
			c8la_pkg::MN_SHL:  op = 16'h800E | x;
			c8la_pkg::MN_RND: begin
				op = 16'hC000 | x | {8'h00, n1[7:0]}; big = (cls_f[1] == c8la_pkg::CL_BIG);
			end
			c8la_pkg::MN_DRW: begin
				op = 16'hD000 | xy | {12'h000, n2[3:0]}; big = (cls_f[2] == c8la_pkg::CL_BIG);
			end
			c8la_pkg::MN_SCD: begin
				op = {12'h00C, n0[3:0]}; big = (cls_f[0] == c8la_pkg::CL_BIG);
			end
			c8la_pkg::MN_SCR:  op = 16'h00FB;
			c8la_pkg::MN_SCL:  op = 16'h00FC;
			c8la_pkg::MN_EXIT: op = 16'h00FD;
			c8la_pkg::MN_LOW:  op = 16'h00FE;
			c8la_pkg::MN_HIGH: op = 16'h00FF;
			default: begin
				op = 16'h0000; big = 1'b0;
			end
		endcase
	end

	// scan one ordinary byte into the token
	logic [TW-1:0]     chars_n;
	logic [LW-1:0]     len_n;
	logic [16:0]       acc_n;
	c8la_pkg::nphase_t phase_n;
	logic              neg_n, hexrun_n;
	logic [3:0]        rdig_n;
	logic [19:0]       acc_x10;
	logic              dig;

	always_comb begin
		chars_n  = chars_q;
		len_n    = len_q;
		acc_n    = acc_q;
		phase_n  = phase_q;
		neg_n    = neg_q;
		hexrun_n = hexrun_q;
		rdig_n   = rdig_q;
		dig      = c8la_pkg::is_digit(lc);
		acc_x10  = ({3'd0, acc_q} * 20'd10) + {12'd0, lc - c8la_pkg::CH_ZERO};
		for (int b = 0; b < c8la_pkg::TOKEN_CHARS; b++) begin
			if (len_q == LW'(b)) begin
				chars_n[b*8 +: 8] = lc;
			end
		end
		if (len_q == LW'(1)) begin
			hexrun_n = c8la_pkg::is_hex(lc);
			rdig_n   = c8la_pkg::is_hex(lc) ? c8la_pkg::hex_val(lc) : 4'h0;
		end else if ((len_q >= LW'(2)) && hexrun_q) begin
			if (c8la_pkg::is_hex(lc)) begin
				rdig_n = c8la_pkg::hex_val(lc);
			end else begin
				hexrun_n = 1'b0;
			end
		end
		unique case (phase_q)
			c8la_pkg::NP_START: begin
				if ((lc >= c8la_pkg::CH_TAB) && (lc <= c8la_pkg::CH_CR)) begin
					phase_n = c8la_pkg::NP_START;
				end else if ((lc == c8la_pkg::CH_PLUS) || (lc == c8la_pkg::CH_MINUS)) begin
					phase_n = c8la_pkg::NP_SIGN;
					neg_n   = (lc == c8la_pkg::CH_MINUS);
				end else if (dig) begin
					phase_n = c8la_pkg::NP_DIGITS;
					acc_n   = {13'd0, c8la_pkg::hex_val(lc)};
				end else begin
					phase_n = c8la_pkg::NP_DONE;
				end
			end
			c8la_pkg::NP_SIGN: begin
				if (dig) begin
					phase_n = c8la_pkg::NP_DIGITS;
					acc_n   = {13'd0, c8la_pkg::hex_val(lc)};
				end else begin
					phase_n = c8la_pkg::NP_DONE;
				end
			end
			c8la_pkg::NP_DIGITS: begin
				if (dig) begin
					acc_n = (acc_x10 > 20'(c8la_pkg::ACC_SAT))
						? c8la_pkg::ACC_SAT : acc_x10[16:0];
				end else begin
					phase_n = c8la_pkg::NP_DONE;
				end
			end
			default: phase_n = c8la_pkg::NP_DONE;
		endcase
		if (len_q < LW'(c8la_pkg::TOKEN_CHARS + 1)) begin
			len_n = len_q + LW'(1);
		end
	end

	// advance line and token state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= c8la_pkg::LINE_BITS'(1);
			pos_q    <= '0;
			chars_q  <= '0;
			len_q    <= '0;
			acc_q    <= '0;
			phase_q  <= c8la_pkg::NP_START;
			neg_q    <= 1'b0;
			hexrun_q <= 1'b0;
			rdig_q   <= '0;
			mn_q     <= c8la_pkg::MN_NONE;
			for (int k = 0; k < 3; k++) begin
				cls_q[k] <= c8la_pkg::CL_ABSENT;
				val_q[k] <= '0;
			end
		end else if (accept) begin
			if (is_nl || is_sp) begin
				chars_q  <= '0;
				len_q    <= '0;
				acc_q    <= '0;
				phase_q  <= c8la_pkg::NP_START;
				neg_q    <= 1'b0;
				hexrun_q <= 1'b0;
				rdig_q   <= '0;
			end else begin
				chars_q  <= chars_n;
				len_q    <= len_n;
				acc_q    <= acc_n;
				phase_q  <= phase_n;
				neg_q    <= neg_n;
				hexrun_q <= hexrun_n;
				rdig_q   <= rdig_n;
			end
			if (is_nl) begin
				if (line_q != '1) begin
					line_q <= line_q + c8la_pkg::LINE_BITS'(1);
				end
				pos_q <= '0;
				mn_q  <= c8la_pkg::MN_NONE;
				for (int k = 0; k < 3; k++) begin
					cls_q[k] <= c8la_pkg::CL_ABSENT;
					val_q[k] <= '0;
				end
			end else if (is_sp) begin
				pos_q <= pos_f;
				mn_q  <= mn_f;
				for (int k = 0; k < 3; k++) begin
					cls_q[k] <= cls_f[k];
					val_q[k] <= val_f[k];
				end
			end
		end
	end

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && is_nl) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_nl) begin
			op_q     <= op;
			status_q <= (mn_f == c8la_pkg::MN_NONE);
			lnum_q   <= 16'(line_q);
			big_q    <= (mn_f != c8la_pkg::MN_NONE) && big;
		end
	end

	assign res_valid         = res_valid_q;
	assign opcode_word       = op_q;
	assign status            = status_q;
	assign line_number       = lnum_q;
	assign operand_too_large = big_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_nl) |=> res_valid_q)
		else $error("newline beat produced no result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q) |-> ((op_q == 16'h0000) && !big_q))
		else $error("unknown mnemonic carries opcode or flag");
	assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter wrapped to zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 3'd4)
		else $error("token position out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_nl && !is_sp && (len_q == '0)) |=> (len_q == LW'(1)))
		else $error("token length did not start");

endmodule
`default_nettype wire

### bench/chip8_line_assembler_tb.sv
// Self-checking testbench for chip8_line_assembler: line predictor, scoreboard and stimulus.
`timescale 1ns / 1ps
module chip8_line_assembler_tb;

	localparam int WATCHDOG_LIMIT = 20000;

	// Expected result of one assembled source line.
	typedef struct {
		logic [15:0] opcode;
		logic        unknown;
		logic [15:0] line;
		logic        oversize;
	} line_result_t;

	// Line assembler predictor plus queue of expected line results.
	class line_scoreboard;
		line_result_t expected_lines[$];
		logic [15:0] line_no;
		logic [2:0]  tok_pos;
		logic [31:0] tok_chars;
		logic [2:0]  tok_len;
		logic [16:0] acc;
		c8la_pkg::mnem_t   mnem;
		c8la_pkg::cls_t    ocls [3];
		logic [15:0]       oval [3];
		c8la_pkg::nphase_t nphase;
		bit          neg, hrun, big;
		logic [3:0]  rdig;
		int          mismatches, checked;
		string mnem_names [24] = '{"sys", "cls", "ret", "call", "jmp", "se", "sne", "ld",
			"add", "and", "or", "xor", "sub", "subn", "shr", "shl", "rnd", "drw", "scd",
			"scr", "scl", "exit", "low", "high"};
		string kw_names [9] = '{"i", "st", "dt", "[i]", "f", "b", "hf", "r", "k"};

		function new();
			line_no = 1;
			clear_line();
			clear_token();
		endfunction

		function void clear_line();
			tok_pos = 0;
			mnem = c8la_pkg::MN_NONE;
			for (int i = 0; i < 3; i++) begin
				ocls[i] = c8la_pkg::CL_ABSENT;
				oval[i] = 0;
			end
			big = 0;
		endfunction

		function void clear_token();
			tok_chars = 0;
			tok_len = 0;
			acc = 0;
			nphase = c8la_pkg::NP_START;
			neg = 0;
			hrun = 0;
			rdig = 0;
		endfunction

		function bit hexc(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "a" && c <= "f");
		endfunction

		function logic [3:0] hexv(logic [7:0] c);
			return (c <= "9") ? 4'(c - "0") : 4'(c - "a" + 10);
		endfunction

		function bit token_matches(string s);
			int n;
			n = s.len();
			if (n != tok_len || n > c8la_pkg::TOKEN_CHARS)
				return 0;
			for (int i = 0; i < n; i++)
				if (tok_chars[8*i +: 8] != s[i])
					return 0;
			return 1;
		endfunction

		// Close the current token: mnemonic or operand classification.
		function void finish_token();
			c8la_pkg::cls_t cls;
			logic [15:0] val;
			logic [7:0]  c0, c1;
			logic [16:0] mag;
			if (tok_len == 0)
				return;
			if (tok_pos == 0) begin
				mnem = c8la_pkg::MN_NONE;
				for (int i = 0; i < 24; i++)
					if (token_matches(mnem_names[i]))
						mnem = c8la_pkg::mnem_t'(i + 1);
			end else if (tok_pos <= 3) begin
				cls = c8la_pkg::CL_ABSENT;
				val = 0;
				c0 = tok_chars[7:0];
				c1 = (tok_len >= 2) ? tok_chars[15:8] : 8'h00;
				for (int i = 0; i < 9; i++)
					if (cls == c8la_pkg::CL_ABSENT && token_matches(kw_names[i]))
						cls = c8la_pkg::cls_t'(c8la_pkg::CL_KW_I + i);
				if (cls == c8la_pkg::CL_ABSENT) begin
					if (c0 == "v" && tok_len >= 2 && hexc(c1)) begin
						cls = c8la_pkg::CL_REG;
						val = {11'd0, (c1 == "0"), rdig};
					end else if (c0 == "i") begin
						cls = c8la_pkg::CL_IWORD;
					end else begin
						mag = (acc > 17'd65535) ? 17'd65535 : acc;
						if (neg) begin
							cls = c8la_pkg::CL_NUM;
							val = 16'(17'd0 - mag);
						end else begin
							cls = (acc > 17'd65535) ? c8la_pkg::CL_BIG : c8la_pkg::CL_NUM;
							val = mag[15:0];
						end
					end
				end
				ocls[tok_pos - 1] = cls;
				oval[tok_pos - 1] = val;
			end
			if (tok_pos < 4)
				tok_pos++;
			clear_token();
		endfunction

		function logic [15:0] reg_of(int k);
			return (ocls[k] == c8la_pkg::CL_REG) ? {12'd0, oval[k][3:0]} : 16'd0;
		endfunction

		function logic [15:0] num_of(int k);
			if (ocls[k] == c8la_pkg::CL_BIG)
				big = 1;
			return (ocls[k] == c8la_pkg::CL_NUM || ocls[k] == c8la_pkg::CL_BIG)
				? oval[k] : 16'd0;
		endfunction

		function logic [15:0] xy(logic [15:0] base);
			return base | (reg_of(0) << 8) | (reg_of(1) << 4);
		endfunction

		// Opcode for the finished line.
		function logic [15:0] encode_line();
			logic [15:0] x, r;
			x = reg_of(0) << 8;
			r = 0;
			case (mnem)
				c8la_pkg::MN_SYS: r = num_of(0) & 16'h0FFF;
				c8la_pkg::MN_CLS: r = 16'h00E0;
				c8la_pkg::MN_RET: r = 16'h00EE;
				c8la_pkg::MN_CALL: r = 16'h2000 | (num_of(0) & 16'h0FFF);
				c8la_pkg::MN_JMP: begin
					if (ocls[0] == c8la_pkg::CL_REG && oval[0][4])
						r = 16'hB000 | (num_of(1) & 16'h0FFF);
					else
						r = 16'h1000 | (num_of(0) & 16'h0FFF);
				end
				c8la_pkg::MN_SE: begin
					if (ocls[1] == c8la_pkg::CL_REG) r = xy(16'h5000);
					else r = 16'h3000 | x | (num_of(1) & 16'h00FF);
				end
				c8la_pkg::MN_SNE: begin
					if (ocls[1] == c8la_pkg::CL_REG) r = xy(16'h9000);
					else r = 16'h4000 | x | (num_of(1) & 16'h00FF);
				end
				c8la_pkg::MN_LD: begin
					case (ocls[0])
						c8la_pkg::CL_KW_I: r = 16'hA000 | (num_of(1) & 16'h0FFF);
						c8la_pkg::CL_KW_ST: r = 16'hF018 | (reg_of(1) << 8);
						c8la_pkg::CL_KW_DT: r = 16'hF015 | (reg_of(1) << 8);
						c8la_pkg::CL_KW_MEM: r = 16'hF055 | (reg_of(1) << 8);
						c8la_pkg::CL_KW_F: r = 16'hF029 | (reg_of(1) << 8);
						c8la_pkg::CL_KW_B: r = 16'hF033 | (reg_of(1) << 8);
						c8la_pkg::CL_KW_HF: r = 16'hF030 | (reg_of(1) << 8);
						c8la_pkg::CL_KW_R: r = 16'hF075 | (reg_of(1) << 8);
						default: begin
							case (ocls[1])
								c8la_pkg::CL_KW_DT: r = 16'hF007 | x;
								c8la_pkg::CL_KW_K: r = 16'hF00A | x;
								c8la_pkg::CL_KW_MEM: r = 16'hF065 | x;
								c8la_pkg::CL_KW_R: r = 16'hF085 | x;
								c8la_pkg::CL_REG: r = xy(16'h8000);
								default: r = 16'h6000 | x | (num_of(1) & 16'h00FF);
							endcase
						end
					endcase
				end
				c8la_pkg::MN_ADD: begin
					if (ocls[0] == c8la_pkg::CL_KW_I || ocls[0] == c8la_pkg::CL_IWORD)
						r = 16'hF01E | (reg_of(1) << 8);
					else if (ocls[1] == c8la_pkg::CL_REG)
						r = xy(16'h8004);
					else
						r = 16'h7000 | x | (num_of(1) & 16'h00FF);
				end
				c8la_pkg::MN_AND: r = xy(16'h8002);
				c8la_pkg::MN_OR: r = xy(16'h8001);
				c8la_pkg::MN_XOR: r = xy(16'h8003);
				c8la_pkg::MN_SUB: r = xy(16'h8005);
				c8la_pkg::MN_SUBN: r = xy(16'h8007);
				c8la_pkg::MN_SHR: r = 16'h8006 | x;
				c8la_pkg::MN_SHL: r = 16'h800E | x;
				c8la_pkg::MN_RND: r = 16'hC000 | x | (num_of(1) & 16'h00FF);
				c8la_pkg::MN_DRW: r = xy(16'hD000) | (num_of(2) & 16'h000F);
				c8la_pkg::MN_SCD: r = 16'h00C0 | (num_of(0) & 16'h000F);
				c8la_pkg::MN_SCR: r = 16'h00FB;
				c8la_pkg::MN_SCL: r = 16'h00FC;
				c8la_pkg::MN_EXIT: r = 16'h00FD;
				c8la_pkg::MN_LOW: r = 16'h00FE;
				c8la_pkg::MN_HIGH: r = 16'h00FF;
				default: r = 0;
			endcase
			return r;
		endfunction

		// Advance the predictor by one accepted character beat.
		function void note_char(logic [7:0] ch);
			line_result_t res;
			logic [7:0]   c;
			int           p, v;
			if (ch == c8la_pkg::CH_NL) begin
				finish_token();
				big = 0;
				res.opcode = encode_line();
				res.unknown = (mnem == c8la_pkg::MN_NONE);
				res.line = line_no;
				res.oversize = (mnem != c8la_pkg::MN_NONE) && big;
				expected_lines.push_back(res);
				if (line_no != 16'hFFFF)
					line_no++;
				clear_line();
				return;
			end
			if (ch == c8la_pkg::CH_SP) begin
				finish_token();
				return;
			end
			c = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
			p = tok_len;
			if (p < c8la_pkg::TOKEN_CHARS)
				tok_chars[8*p +: 8] = c;
			if (p == 1) begin
				hrun = hexc(c);
				rdig = hrun ? hexv(c) : 4'd0;
			end else if (p >= 2 && hrun) begin
				if (hexc(c)) rdig = hexv(c);
				else hrun = 0;
			end
			case (nphase)
				c8la_pkg::NP_START: begin
					if (c >= 8'h09 && c <= 8'h0D) begin
					end else if (c == "+" || c == "-") begin
						nphase = c8la_pkg::NP_SIGN;
						neg = (c == "-");
					end else if (c >= "0" && c <= "9") begin
						nphase = c8la_pkg::NP_DIGITS;
						acc = 17'(c - "0");
					end else nphase = c8la_pkg::NP_DONE;
				end
				c8la_pkg::NP_SIGN: begin
					if (c >= "0" && c <= "9") begin
						nphase = c8la_pkg::NP_DIGITS;
						acc = 17'(c - "0");
					end else nphase = c8la_pkg::NP_DONE;
				end
				c8la_pkg::NP_DIGITS: begin
					if (c >= "0" && c <= "9") begin
						v = int'(acc) * 10 + int'(c - "0");
						acc = (v > 65536) ? 17'h10000 : 17'(v);
					end else nphase = c8la_pkg::NP_DONE;
				end
				default: ;
			endcase
			if (p < c8la_pkg::TOKEN_CHARS + 1)
				tok_len = 3'(p + 1);
		endfunction

		// Compare one result beat with the oldest expected line.
		function void check_result(logic [15:0] op, logic st, logic [15:0] ln, logic ovr);
			line_result_t e;
			checked++;
			if (expected_lines.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: op=%h status=%b line=%0d flag=%b",
						op, st, ln, ovr);
				return;
			end
			e = expected_lines.pop_front();
			if (op !== e.opcode || st !== e.unknown || ln !== e.line || ovr !== e.oversize) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch line %0d: expected op=%h st=%b ln=%0d flag=%b,",
						" got op=%h st=%b ln=%0d flag=%b"},
						e.line, e.opcode, e.unknown, e.line, e.oversize, op, st, ln, ovr);
			end
		endfunction

		function int pending();
			return expected_lines.size();
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        char_valid = 0;
	logic        char_stall;
	logic [7:0]  character = 8'h00;
	logic        res_valid;
	logic        res_stall = 0;
	logic [15:0] opcode_word;
	logic        status;
	logic [15:0] line_number;
	logic        operand_too_large;

	line_scoreboard sb = new();
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          chars_sent = 0;
	int          quiet_cycles = 0;
	logic [7:0]  line_bytes[$];
	string       hex_digits = "0123456789abcdef";

	chip8_line_assembler dut (
		.clk(clk), .arst_n(arst_n),
		.char_valid(char_valid), .char_stall(char_stall), .character(character),
		.res_valid(res_valid), .res_stall(res_stall),
		.opcode_word(opcode_word), .status(status), .line_number(line_number),
		.operand_too_large(operand_too_large)
	);

	always #6 clk = ~clk;

	// Randomly hold off the result channel.
	always @(negedge clk)
		res_stall <= ($urandom_range(99) < recv_stall_pct);

	// Check result beats and watch for a hung handshake.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(opcode_word, status, line_number, operand_too_large);
		if ((char_valid && !char_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d lines outstanding", sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Send one character beat, with random idle cycles ahead of it.
	task automatic send_char(logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 0;
			@(negedge clk);
		end
		char_valid <= 1;
		character <= c;
		do @(posedge clk); while (char_stall);
		sb.note_char(c);
		chars_sent++;
	endtask

	task automatic flush_line_bytes();
		while (line_bytes.size() > 0)
			send_char(line_bytes.pop_front());
	endtask

	task automatic drain();
		@(negedge clk);
		char_valid <= 0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	// Queue text, letters in random case when asked.
	function automatic void add_text(string s, bit mix);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix && c >= "a" && c <= "z" && $urandom_range(1))
				c = c - 8'd32;
			line_bytes.push_back(c);
		end
	endfunction

	function automatic void add_spaces();
		repeat ($urandom_range(1, 3)) line_bytes.push_back(c8la_pkg::CH_SP);
	endfunction

	function automatic void add_operand();
		logic [7:0] b;
		case ($urandom_range(11))
			0, 1, 2: begin
				add_text("v", 1);
				repeat ($urandom_range(3) == 0 ? $urandom_range(2, 4) : 1)
					add_text(hex_digits.substr($urandom_range(15), $urandom_range(15)), 1);
				if ($urandom_range(9) == 0) add_text("g7", 1);
			end
			3: add_text(sb.kw_names[$urandom_range(8)], 1);
			4, 5: add_text($sformatf("%0d", $urandom_range(300)), 0);
			6: add_text($sformatf("%0d", $urandom_range(70000)), 0);
			7: begin
				case ($urandom_range(3))
					0: add_text("65535", 0);
					1: add_text("65536", 0);
					2: add_text("4294967295123", 0);
					default: add_text($sformatf("%0d", $urandom_range(65536, 5000000)), 0);
				endcase
			end
			8: add_text($sformatf("%s%0d", $urandom_range(1) ? "-" : "+",
				$urandom_range(100000)), 0);
			9: begin
				b = $urandom_range(1) ? 8'h09 : 8'(13 - $urandom_range(2));
				line_bytes.push_back(b);
				add_text($sformatf("%0d", $urandom_range(5000)), 0);
				if ($urandom_range(3) == 0) add_text("x", 0);
			end
			10: add_text($urandom_range(1) ? "i" : "ix5", 1);
			default: begin
				repeat ($urandom_range(1, 6)) begin
					b = $urandom_range(255);
					if (b == c8la_pkg::CH_NL || b == c8la_pkg::CH_SP) b = 8'h00;
					line_bytes.push_back(b);
				end
			end
		endcase
	endfunction

	// Build one random line: mostly well formed, some junk.
	task automatic send_random_line();
		logic [7:0] b;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(12)) begin
				b = $urandom_range(255);
				line_bytes.push_back(b);
			end
		end else begin
			if ($urandom_range(4) == 0) add_spaces();
			if ($urandom_range(14) == 0) add_text("jp", 1);
			else add_text(sb.mnem_names[$urandom_range(23)], 1);
			repeat ($urandom_range(4)) begin
				add_spaces();
				add_operand();
			end
			if ($urandom_range(4) == 0) add_spaces();
		end
		line_bytes.push_back(c8la_pkg::CH_NL);
		flush_line_bytes();
	endtask

	task automatic send_text_line(string s);
		add_text(s, 0);
		line_bytes.push_back(c8la_pkg::CH_NL);
		flush_line_bytes();
	endtask

	initial begin
		int start_count;
		string directed [] = '{"sys 4096", "CLS", "ret", "call 70000", "jmp 100",
			"jmp v0 4000", "se v3 vA", "se v1 255", "sne v2 v4", "sne vf -1",
			"ld i 300", "ld st v5", "ld dt v6", "ld [i] v7", "ld f v8", "ld b v9",
			"ld hf va", "ld r vb", "ld vc dt", "ld vd k", "ld ve [i]", "ld v1 r",
			"ld v2 v3", "ld v4 +77", "add i v3", "add I v1", "add v1 v2", "add v1 5",
			"and v1 v2", "or v3 v4", "xor v5 v6", "sub v7 v8", "subn v9 va", "shr vb",
			"shl vc", "rnd vd 99999", "drw v1 v2 15", "scd 3", "scr", "scl", "exit",
			"low", "high", "", "foo v1", "  LD   V1a2   12 extra more", "calls 5",
			"ld v1 -99999", "sys ix"};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed lines, then odd control bytes inside a token.
		foreach (directed[i])
			send_text_line(directed[i]);
		add_text("ld v1 ", 0);
		line_bytes.push_back(8'h0D);
		line_bytes.push_back(8'h09);
		add_text("42", 0);
		line_bytes.push_back(c8la_pkg::CH_NL);
		line_bytes.push_back(8'h00);
		line_bytes.push_back(8'hFF);
		line_bytes.push_back(c8la_pkg::CH_NL);
		flush_line_bytes();

		// Random lines under three idling profiles, draining between them.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 70 : 0;
			recv_stall_pct = (phase == 0) ? 70 : (phase == 1) ? 32 : 0;
			start_count = chars_sent;
			while (chars_sent - start_count < 420)
				send_random_line();
			drain();
		end

		drain();
		repeat (10) @(posedge clk);
		$display("sent %0d character beats, checked %0d line results", chars_sent, sb.checked);
		$display("covered all mnemonics, register and keyword operands, oversize and negative values");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else begin
			$display("%0d mismatches, %0d lines outstanding", sb.mismatches, sb.pending());
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
